// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define I2CTS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition at one edge leads to another at the next edge.
`define I2CTS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/i2cts_pkg.sv =====
// Types, codes and constants of the I2C transaction sequencer.
package i2cts_pkg;

	localparam int BUF_DEPTH     = 256;
	localparam int BUF_AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int BUF_WRAP_LAST = 255 % BUF_DEPTH;

	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_LOAD  = 3'd2;
	localparam logic [2:0] KIND_EVENT = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	localparam logic [7:0] ST_BUS_ERR      = 8'h00;
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_RESTART      = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
	localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
	localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST     = 8'h38;
	localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
	localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
	localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
	localparam logic [7:0] ST_SR_SLA       = 8'h60;
	localparam logic [7:0] ST_SR_SLA_ARB   = 8'h68;
	localparam logic [7:0] ST_SR_GEN       = 8'h70;
	localparam logic [7:0] ST_SR_GEN_ARB   = 8'h78;
	localparam logic [7:0] ST_SR_DATA      = 8'h80;
	localparam logic [7:0] ST_SR_DATA_NACK = 8'h88;
	localparam logic [7:0] ST_SR_GDATA     = 8'h90;
	localparam logic [7:0] ST_SR_GDATA_NAK = 8'h98;
	localparam logic [7:0] ST_SR_STOP      = 8'hA0;
	localparam logic [7:0] ST_ST_SLA       = 8'hA8;
	localparam logic [7:0] ST_ST_SLA_ARB   = 8'hB0;
	localparam logic [7:0] ST_ST_DATA_ACK  = 8'hB8;
	localparam logic [7:0] ST_ST_DATA_NACK = 8'hC0;
	localparam logic [7:0] ST_ST_LAST_ACK  = 8'hC8;
	localparam logic [7:0] ST_MASK         = 8'hF8;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_MT_ADDR    = 4'd1;
	localparam logic [3:0] ERR_MT_DATA    = 4'd2;
	localparam logic [3:0] ERR_MR_ADDR    = 4'd3;
	localparam logic [3:0] ERR_ARB        = 4'd4;
	localparam logic [3:0] ERR_ARB_ST     = 4'd5;
	localparam logic [3:0] ERR_ARB_SR     = 4'd6;
	localparam logic [3:0] ERR_ST_NACK    = 4'd7;
	localparam logic [3:0] ERR_SR_NACK    = 4'd8;
	localparam logic [3:0] ERR_BUS        = 4'd9;

	typedef enum logic [2:0] {
		MODE_DISC  = 3'd0,
		MODE_IDLE  = 3'd1,
		MODE_SEIZE = 3'd2,
		MODE_MTX   = 3'd3,
		MODE_MRX   = 3'd4,
		MODE_STX   = 3'd5,
		MODE_SRX   = 3'd6,
		MODE_SRXW  = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_ACK     = 3'd1,
		CMD_LAST    = 3'd2,
		CMD_START   = 3'd3,
		CMD_STOP    = 3'd4,
		CMD_RESTART = 3'd5
	} cmd_t;

	typedef enum logic [4:0] {
		OP_NOP             = 5'd0,
		OP_REQ_WR          = 5'd1,
		OP_REQ_RD          = 5'd2,
		OP_LOAD            = 5'd3,
		OP_CLEAR           = 5'd4,
		OP_EV_START        = 5'd5,
		OP_EV_MT_SLA_ACK   = 5'd6,
		OP_EV_MT_SLA_NACK  = 5'd7,
		OP_EV_MT_DATA_ACK  = 5'd8,
		OP_EV_MT_DATA_NACK = 5'd9,
		OP_EV_ARB_LOST     = 5'd10,
		OP_EV_MR_SLA_ACK   = 5'd11,
		OP_EV_MR_SLA_NACK  = 5'd12,
		OP_EV_MR_DATA_ACK  = 5'd13,
		OP_EV_MR_DATA_NACK = 5'd14,
		OP_EV_ST_SLA       = 5'd15,
		OP_EV_ST_SLA_ARB   = 5'd16,
		OP_EV_ST_DONE      = 5'd17,
		OP_EV_ST_NACK      = 5'd18,
		OP_EV_SR_SLA       = 5'd19,
		OP_EV_SR_SLA_ARB   = 5'd20,
		OP_EV_SR_DATA      = 5'd21,
		OP_EV_SR_DATA_NACK = 5'd22,
		OP_EV_SR_STOP      = 5'd23,
		OP_EV_BUS_ERR      = 5'd24,
		OP_EV_UNKNOWN      = 5'd25
	} op_t;

	typedef enum logic [1:0] {
		DB_NONE   = 2'd0,
		DB_DIRECT = 2'd1,
		DB_STORE  = 2'd2
	} db_sel_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [6:0] remote_address;
		logic [7:0] length;
		logic [7:0] byte_index;
		logic [7:0] byte_value;
		logic [7:0] status_code;
		logic [7:0] slave_tx_byte;
	} req_t;

	typedef struct packed {
		logic       drive_valid;
		logic [7:0] drive_byte;
		logic [2:0] bus_command;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic [7:0] rx_index;
		logic       rx_as_slave;
		logic       data_ready;
		logic [2:0] mode;
		logic [3:0] error_code;
	} res_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		op_t               op;
		logic [6:0]        addr;
		logic [7:0]        len;
		logic [BUF_AW-1:0] pos;
		logic [7:0]        bval;
		logic [7:0]        stx;
	} op_item_t;

	typedef struct packed {
		logic we;
		logic val;
	} cfg_wr_t;

endpackage

// ===== sv/i2c_transaction_sequencer_core.sv =====
// Top level of the I2C transaction sequencer: configuration port and front/back wiring.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  items in  | push / full            | request (req_t)
//  results   | pop / empty            | result (res_t), oldest while empty low
//  config    | psel penable pwrite    | paddr, pwdata, prdata; pready tied high
//
// One item per clock sustained while neither side stalls; every item gives exactly one result.
// An accepted item passes through the front register, the item queue, the second
// back stage (sequencer result and store read) and the result queue to the result ports.
// The transmit store read port (one read per item) sets the second back stage.
// Either side may stall on its own: the item queue and the two-entry result
// queue absorb the difference. arst_n clears all control state; store contents
// are undefined until loaded.
module i2c_transaction_sequencer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  i2cts_pkg::req_t    request,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output i2cts_pkg::res_t    result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import i2cts_pkg::*;

	logic       bus_enable_q;
	logic [7:0] retry_limit_q;
	logic       cfg_wr;
	cfg_wr_t    cfg;

	logic       q_push;
	op_item_t   q_wdata;
	logic       q_full;
	op_item_t   q_rdata;
	logic       q_empty;
	logic       q_pop;

	// Register map: bit 2 of the byte address picks the register.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg.we  = cfg_wr && !paddr[2];
	assign cfg.val = pwdata[0];
	assign prdata  = paddr[2] ? {24'd0, retry_limit_q} : {31'd0, bus_enable_q};

	// Hold configuration; the mode reacts to enable writes inside the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_enable_q  <= 1'b0;
			retry_limit_q <= 8'd3;
		end else if (cfg_wr) begin
			if (paddr[2])
				retry_limit_q <= pwdata[7:0];
			else
				bus_enable_q <= pwdata[0];
		end
	end

	// Accept and classify incoming items.
	i2cts_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.request (request),
		.full    (full),
		.q_push  (q_push),
		.q_item  (q_wdata),
		.q_full  (q_full)
	);

	// Decouple classification from sequencing.
	i2cts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Advance the bus transaction and deliver results.
	i2cts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.bus_enable  (bus_enable_q),
		.retry_limit (retry_limit_q),
		.cfg         (cfg),
		.item        (q_rdata),
		.item_valid  (!q_empty),
		.item_pop    (q_pop),
		.result      (result),
		.empty       (empty),
		.pop         (pop)
	);

endmodule

// ===== sv/i2cts_front.sv =====
// Front end: accepts items and classifies them into operations.
module i2cts_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  i2cts_pkg::req_t     request,
	output logic                full,
	output logic                q_push,
	output i2cts_pkg::op_item_t q_item,
	input  logic                q_full
);
	import i2cts_pkg::*;

	op_item_t item_s1;
	logic     valid_s1;
	op_item_t cls;
	logic     accept;
	logic [7:0] st;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign st     = request.status_code & ST_MASK;

	always_comb begin
		cls.addr = request.remote_address;
		cls.len  = (request.length == 8'd0) ? 8'd1 : request.length;
		cls.pos  = request.byte_index[BUF_AW-1:0];
		cls.bval = request.byte_value;
		cls.stx  = request.slave_tx_byte;
		cls.op   = OP_NOP;
		unique case (request.kind)
			KIND_WRITE: cls.op = OP_REQ_WR;
			KIND_READ:  cls.op = OP_REQ_RD;
			KIND_CLEAR: cls.op = OP_CLEAR;
			KIND_LOAD: begin
				// turn loads past the end of the store into no-ops
				if ({1'b0, request.byte_index} < 9'(BUF_DEPTH))
					cls.op = OP_LOAD;
			end
			KIND_EVENT: begin
				unique case (st)
					ST_START, ST_RESTART:             cls.op = OP_EV_START;
					ST_MT_SLA_ACK:                    cls.op = OP_EV_MT_SLA_ACK;
					ST_MT_SLA_NACK:                   cls.op = OP_EV_MT_SLA_NACK;
					ST_MT_DATA_ACK:                   cls.op = OP_EV_MT_DATA_ACK;
					ST_MT_DATA_NACK:                  cls.op = OP_EV_MT_DATA_NACK;
					ST_ARB_LOST:                      cls.op = OP_EV_ARB_LOST;
					ST_MR_SLA_ACK:                    cls.op = OP_EV_MR_SLA_ACK;
					ST_MR_SLA_NACK:                   cls.op = OP_EV_MR_SLA_NACK;
					ST_MR_DATA_ACK:                   cls.op = OP_EV_MR_DATA_ACK;
					ST_MR_DATA_NACK:                  cls.op = OP_EV_MR_DATA_NACK;
					ST_ST_SLA:                        cls.op = OP_EV_ST_SLA;
					ST_ST_SLA_ARB:                    cls.op = OP_EV_ST_SLA_ARB;
					ST_ST_DATA_ACK, ST_ST_LAST_ACK:   cls.op = OP_EV_ST_DONE;
					ST_ST_DATA_NACK:                  cls.op = OP_EV_ST_NACK;
					ST_SR_SLA, ST_SR_GEN:             cls.op = OP_EV_SR_SLA;
					ST_SR_SLA_ARB, ST_SR_GEN_ARB:     cls.op = OP_EV_SR_SLA_ARB;
					ST_SR_DATA, ST_SR_GDATA:          cls.op = OP_EV_SR_DATA;
					ST_SR_DATA_NACK, ST_SR_GDATA_NAK: cls.op = OP_EV_SR_DATA_NACK;
					ST_SR_STOP:                       cls.op = OP_EV_SR_STOP;
					ST_BUS_ERR:                       cls.op = OP_EV_BUS_ERR;
					default:                          cls.op = OP_EV_UNKNOWN;
				endcase
			end
			default: cls.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	assign q_push = valid_s1;
	assign q_item = item_s1;

endmodule

// ===== sv/i2cts_queue.sv =====
// Two-entry queue of classified items between front and back.
`include "assert_macros.svh"

module i2cts_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  i2cts_pkg::op_item_t wdata,
	output logic                full,
	input  logic                pop,
	output i2cts_pkg::op_item_t rdata,
	output logic                empty
);
	import i2cts_pkg::*;

	op_item_t   slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	`I2CTS_ASSERT(a_q_cnt_range, cnt_q <= 2'd2, "item queue count out of range")

endmodule

// ===== sv/i2cts_back.sv =====
// Back end: runs the transaction sequencer, owns the transmit store and result queue.
`include "assert_macros.svh"

module i2cts_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bus_enable,
	input  logic [7:0]          retry_limit,
	input  i2cts_pkg::cfg_wr_t  cfg,
	input  i2cts_pkg::op_item_t item,
	input  logic                item_valid,
	output logic                item_pop,
	output i2cts_pkg::res_t     result,
	output logic                empty,
	input  logic                pop
);
	import i2cts_pkg::*;

	// sequencer state
	mode_t             mode_q;
	mode_t             intent_q;
	logic [6:0]        taddr_q;
	logic [7:0]        xlen_q;
	logic [7:0]        xidx_q;
	logic [BUF_AW-1:0] pos_q;
	logic [7:0]        retry_q;
	logic [3:0]        err_q;
	logic              rdy_q;

	mode_t             n_mode;
	mode_t             n_intent;
	logic [6:0]        n_taddr;
	logic [7:0]        n_xlen;
	logic [7:0]        n_xidx;
	logic [BUF_AW-1:0] n_pos;
	logic [7:0]        n_retry;
	logic [3:0]        n_err;
	logic              n_rdy;

	logic [7:0]        store_q [BUF_DEPTH];
	logic [7:0]        rdata_q;
	logic [BUF_AW-1:0] raddr;

	res_t              res_c;
	db_sel_t           sel_c;
	cmd_t              cmd_c;
	op_t               op_eff;
	res_t              res_s2;
	db_sel_t           sel_s2;
	logic              v_s2;
	logic              s2_adv;
	logic              fire;

	logic              nack_out;
	logic [7:0]        retry_nack;
	logic [BUF_AW-1:0] pos_inc;
	logic [BUF_AW-1:0] pos_dec;

	res_t              ofifo_q [2];
	logic              owr_q;
	logic              ord_q;
	logic [1:0]        ocnt_q;
	logic              opop;
	res_t              res_fin;

	assign opop     = pop && !empty;
	assign empty    = (ocnt_q == 2'd0);
	assign s2_adv   = v_s2 && ((ocnt_q != 2'd2) || opop);
	assign fire     = item_valid && (!v_s2 || s2_adv);
	assign item_pop = fire;
	assign result   = ofifo_q[ord_q];

	assign nack_out   = (retry_q >= retry_limit);
	assign retry_nack = nack_out ? 8'd0 : ((retry_q != 8'hFF) ? retry_q + 8'd1 : retry_q);

	// store position tracks the transfer index modulo the store depth
	assign pos_inc = (xidx_q == 8'hFF) ? '0 :
		(pos_q == BUF_AW'(BUF_DEPTH - 1)) ? '0 : pos_q + 1'b1;
	assign pos_dec = (xidx_q == 8'd0) ? BUF_AW'(BUF_WRAP_LAST) :
		(pos_q == '0) ? BUF_AW'(BUF_DEPTH - 1) : pos_q - 1'b1;

	assign op_eff = (bus_enable || item.op == OP_LOAD || item.op == OP_CLEAR ||
		item.op == OP_NOP) ? item.op : OP_NOP;

	always_comb begin
		n_mode   = mode_q;
		n_intent = intent_q;
		n_taddr  = taddr_q;
		n_xlen   = xlen_q;
		n_xidx   = xidx_q;
		n_pos    = pos_q;
		n_retry  = retry_q;
		n_err    = err_q;
		n_rdy    = rdy_q;
		raddr    = pos_q;
		sel_c    = DB_NONE;
		cmd_c    = CMD_NONE;
		res_c    = '0;
		unique case (op_eff)
			OP_NOP, OP_LOAD: ;
			OP_CLEAR: n_err = ERR_NONE;
			OP_REQ_WR, OP_REQ_RD: begin
				n_rdy    = 1'b0;
				n_taddr  = item.addr;
				n_xlen   = item.len;
				n_xidx   = 8'd0;
				n_pos    = '0;
				n_retry  = 8'd0;
				n_intent = (op_eff == OP_REQ_WR) ? MODE_MTX : MODE_MRX;
				n_mode   = MODE_SEIZE;
				cmd_c    = CMD_START;
			end
			OP_EV_START: begin
				res_c.drive_byte = {taddr_q, 1'b0};
				if (intent_q == MODE_MTX) begin
					n_mode = MODE_MTX;
				end else if (intent_q == MODE_MRX) begin
					n_mode = MODE_MRX;
					res_c.drive_byte = {taddr_q, 1'b1};
				end
				sel_c = DB_DIRECT;
				cmd_c = CMD_ACK;
			end
			OP_EV_MT_SLA_ACK: begin
				sel_c   = DB_STORE;
				n_xidx  = xidx_q + 8'd1;
				n_pos   = pos_inc;
				n_retry = 8'd0;
				cmd_c   = CMD_ACK;
			end
			OP_EV_MT_SLA_NACK, OP_EV_MR_SLA_NACK: begin
				n_retry = retry_nack;
				if (nack_out) begin
					n_err    = (op_eff == OP_EV_MT_SLA_NACK) ? ERR_MT_ADDR : ERR_MR_ADDR;
					n_mode   = MODE_IDLE;
					n_intent = MODE_IDLE;
					cmd_c    = CMD_STOP;
				end else begin
					cmd_c    = CMD_RESTART;
				end
			end
			OP_EV_MT_DATA_ACK: begin
				n_retry = 8'd0;
				if (xlen_q == xidx_q) begin
					n_mode   = MODE_IDLE;
					n_intent = MODE_IDLE;
					cmd_c    = CMD_STOP;
				end else begin
					sel_c  = DB_STORE;
					n_xidx = xidx_q + 8'd1;
					n_pos  = pos_inc;
					cmd_c  = CMD_ACK;
				end
			end
			OP_EV_MT_DATA_NACK: begin
				n_retry = retry_nack;
				if (nack_out) begin
					n_err    = ERR_MT_DATA;
					n_mode   = MODE_IDLE;
					n_intent = MODE_IDLE;
					cmd_c    = CMD_STOP;
				end else begin
					// resend the byte that was refused
					raddr = pos_dec;
					sel_c = DB_STORE;
					cmd_c = CMD_ACK;
				end
			end
			OP_EV_ARB_LOST: begin
				n_err    = ERR_ARB;
				n_mode   = MODE_IDLE;
				n_intent = MODE_IDLE;
				cmd_c    = CMD_ACK;
			end
			OP_EV_MR_SLA_ACK: begin
				n_rdy   = 1'b0;
				n_retry = 8'd0;
				cmd_c   = (xlen_q <= 8'd1) ? CMD_LAST : CMD_ACK;
			end
			OP_EV_MR_DATA_ACK: begin
				res_c.rx_valid = 1'b1;
				res_c.rx_byte  = item.bval;
				res_c.rx_index = xidx_q;
				n_xidx = xidx_q + 8'd1;
				n_pos  = pos_inc;
				cmd_c  = ({1'b0, xidx_q} + 9'd2 >= {1'b0, xlen_q}) ? CMD_LAST : CMD_ACK;
			end
			OP_EV_MR_DATA_NACK: begin
				res_c.rx_valid = 1'b1;
				res_c.rx_byte  = item.bval;
				res_c.rx_index = xidx_q;
				n_xidx   = xidx_q + 8'd1;
				n_pos    = pos_inc;
				n_rdy    = 1'b1;
				n_mode   = MODE_IDLE;
				n_intent = MODE_IDLE;
				cmd_c    = CMD_STOP;
			end
			OP_EV_ST_SLA, OP_EV_ST_SLA_ARB: begin
				if (op_eff == OP_EV_ST_SLA_ARB)
					n_err = ERR_ARB_ST;
				n_mode           = MODE_STX;
				sel_c            = DB_DIRECT;
				res_c.drive_byte = item.stx;
				cmd_c            = CMD_ACK;
			end
			OP_EV_ST_DONE, OP_EV_SR_STOP: begin
				n_mode   = MODE_IDLE;
				n_intent = MODE_IDLE;
				cmd_c    = CMD_ACK;
			end
			OP_EV_ST_NACK: begin
				n_err    = ERR_ST_NACK;
				n_mode   = MODE_IDLE;
				n_intent = MODE_IDLE;
				cmd_c    = CMD_ACK;
			end
			OP_EV_SR_SLA, OP_EV_SR_SLA_ARB: begin
				if (op_eff == OP_EV_SR_SLA_ARB)
					n_err = ERR_ARB_SR;
				n_mode = MODE_SRX;
				n_rdy  = 1'b0;
				cmd_c  = CMD_ACK;
			end
			OP_EV_SR_DATA, OP_EV_SR_DATA_NACK: begin
				if (op_eff == OP_EV_SR_DATA_NACK)
					n_err = ERR_SR_NACK;
				res_c.rx_valid    = 1'b1;
				res_c.rx_byte     = item.bval;
				res_c.rx_as_slave = 1'b1;
				n_mode   = MODE_SRXW;
				n_intent = MODE_SRXW;
				n_rdy    = 1'b1;
				cmd_c    = CMD_ACK;
			end
			OP_EV_BUS_ERR: begin
				n_err    = ERR_BUS;
				n_mode   = MODE_IDLE;
				n_intent = MODE_IDLE;
				cmd_c    = CMD_ACK;
			end
			OP_EV_UNKNOWN: cmd_c = CMD_STOP;
			default: ;
		endcase
		res_c.drive_valid = (sel_c != DB_NONE);
		res_c.bus_command = cmd_c;
		res_c.data_ready  = n_rdy;
		res_c.mode        = n_mode;
		res_c.error_code  = n_err;
	end

	// transmit store: one write port for loads, one registered read port
	always_ff @(posedge clk) begin
		if (fire && op_eff == OP_LOAD)
			store_q[item.pos] <= item.bval;
		if (fire)
			rdata_q <= store_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DISC;
			intent_q <= MODE_IDLE;
			taddr_q  <= 7'd0;
			xlen_q   <= 8'd0;
			xidx_q   <= 8'd0;
			pos_q    <= '0;
			retry_q  <= 8'd0;
			err_q    <= ERR_NONE;
			rdy_q    <= 1'b0;
		end else if (cfg.we) begin
			if (!cfg.val)
				mode_q <= MODE_DISC;
			else if (mode_q == MODE_DISC)
				mode_q <= MODE_IDLE;
		end else if (fire) begin
			mode_q   <= n_mode;
			intent_q <= n_intent;
			taddr_q  <= n_taddr;
			xlen_q   <= n_xlen;
			xidx_q   <= n_xidx;
			pos_q    <= n_pos;
			retry_q  <= n_retry;
			err_q    <= n_err;
			rdy_q    <= n_rdy;
		end
	end

	// second stage waits for the store read
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_c;
			sel_s2 <= sel_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (fire)
			v_s2 <= 1'b1;
		else if (s2_adv)
			v_s2 <= 1'b0;
	end

	always_comb begin
		res_fin = res_s2;
		if (sel_s2 == DB_STORE)
			res_fin.drive_byte = rdata_q;
	end

	// result queue
	always_ff @(posedge clk) begin
		if (s2_adv)
			ofifo_q[owr_q] <= res_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (s2_adv)
				owr_q <= !owr_q;
			if (opop)
				ord_q <= !ord_q;
			if (s2_adv && !opop)
				ocnt_q <= ocnt_q + 2'd1;
			else if (opop && !s2_adv)
				ocnt_q <= ocnt_q - 2'd1;
		end
	end

	`I2CTS_ASSERT(a_disc_matches_enable, (mode_q == MODE_DISC) == !bus_enable, "mode and enable disagree")
	`I2CTS_ASSERT(a_seize_not_ready, (mode_q != MODE_SEIZE) || !rdy_q, "ready flag set while seizing")
	`I2CTS_ASSERT_NEXT(a_s2_hold, v_s2 && !s2_adv, v_s2 && $stable(res_s2), "stalled result lost")
	`I2CTS_ASSERT(a_ofifo_range, ocnt_q <= 2'd2, "result queue count out of range")

endmodule
